### src/scp_pkg.sv
// Package for the serial command and time parser.
// Event and colour codes, character constants and the time check result type.
// No dependencies.
package scp_pkg;

  typedef enum logic [1:0] {
    EV_COLOUR = 2'd0,
    EV_TIMER  = 2'd1,
    EV_ERROR  = 2'd2,
    EV_DEBUG  = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    COL_RED    = 2'd0,
    COL_YELLOW = 2'd1,
    COL_GREEN  = 2'd2
  } colour_e;

  localparam logic ERR_NON_DIGIT = 1'b0;
  localparam logic ERR_RANGE     = 1'b1;

  localparam int unsigned EntryLen = 6;
  localparam int unsigned SecsW    = 17;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_UP_G   = 8'h47;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_Y   = 8'h59;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  localparam logic [6:0] MAX_HOURS = 7'd23;
  localparam logic [6:0] MAX_MINSEC = 7'd59;

  typedef logic [EntryLen-1:0][3:0] digits_t;

  typedef struct packed {
    logic             range_err;
    logic [SecsW-1:0] secs;
  } time_res_t;

endpackage

### src/serial_command_time_parser.sv
// Top level of the serial command and time parser.
// Input register, command/entry decode, result register. Depends on scp_pkg
// and scp_time_check.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+----------------------------------------
//  in      | in_valid_i  | in_stall_o  | rx_byte_i
//  out     | out_valid_o | out_stall_i | event_kind_o light_colour_o
//          |             |             | delay_seconds_o error_code_o debug_enabled_o
//
// One word per cycle while in_stall_o is low; input and result are both registered.
// The decode stage commits a word when the result register is free or the
// word gives no result, so words without results drain under output stall.
// Reset: no entry, timer colour red, debug flag on; digit store is not reset.
module serial_command_time_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              rx_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              event_kind_o,
  output logic [1:0]              light_colour_o,
  output logic [scp_pkg::SecsW-1:0] delay_seconds_o,
  output logic                    error_code_o,
  output logic                    debug_enabled_o
);
  import scp_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        entry_active_q, entry_active_d;
  logic [2:0]  entry_count_q, entry_count_d;
  logic        saw_non_digit_q, saw_non_digit_d;
  colour_e     timer_colour_q, timer_colour_d;
  logic        debug_flag_q, debug_flag_d;
  digits_t     digit_store_q;
  logic        out_valid_q, out_valid_d;

  event_kind_e kind_q, kind_d;
  colour_e     colour_q, colour_d;
  logic [SecsW-1:0] secs_q, secs_d;
  logic        err_q, err_d;
  logic        dbg_q, dbg_d;

  logic        has_result, store_we, advance, fire, accept;
  logic        is_digit, is_eol;
  logic [7:0]  upper;
  logic [3:0]  cur_digit;
  digits_t     full_digits;
  time_res_t   tres;

  assign is_digit  = (s1_byte_q >= CH_ZERO) && (s1_byte_q <= CH_NINE);
  assign is_eol    = (s1_byte_q == CH_CR) || (s1_byte_q == CH_LF);
  assign upper     = ((s1_byte_q >= CH_LO_A) && (s1_byte_q <= CH_LO_Z)) ?
                     s1_byte_q - CASE_DIFF : s1_byte_q;
  assign cur_digit = is_digit ? 4'(s1_byte_q - CH_ZERO) : 4'd0;

  always_comb begin
    full_digits = digit_store_q;
    full_digits[EntryLen-1] = cur_digit;
  end

  scp_time_check u_time_check (
    .digits_i(full_digits),
    .res_o   (tres)
  );

  always_comb begin
    has_result      = 1'b0;
    store_we        = 1'b0;
    entry_active_d  = entry_active_q;
    entry_count_d   = entry_count_q;
    saw_non_digit_d = saw_non_digit_q;
    timer_colour_d  = timer_colour_q;
    debug_flag_d    = debug_flag_q;
    kind_d          = EV_COLOUR;
    colour_d        = COL_RED;
    secs_d          = '0;
    err_d           = ERR_NON_DIGIT;
    dbg_d           = 1'b0;
    if (entry_active_q) begin
      if (is_eol) begin
        entry_active_d  = 1'b0;
        entry_count_d   = '0;
        saw_non_digit_d = 1'b0;
      end else if (entry_count_q == 3'(EntryLen - 1)) begin
        has_result      = 1'b1;
        entry_active_d  = 1'b0;
        entry_count_d   = '0;
        saw_non_digit_d = 1'b0;
        kind_d          = EV_ERROR;
        if (saw_non_digit_q || !is_digit) begin
          err_d = ERR_NON_DIGIT;
        end else if (tres.range_err) begin
          err_d = ERR_RANGE;
        end else begin
          kind_d   = EV_TIMER;
          colour_d = timer_colour_q;
          secs_d   = tres.secs;
        end
      end else begin
        store_we      = 1'b1;
        entry_count_d = entry_count_q + 3'd1;
        if (!is_digit) begin
          saw_non_digit_d = 1'b1;
        end
      end
    end else begin
      case (upper)
        CH_UP_A: begin
          entry_active_d  = 1'b1;
          entry_count_d   = '0;
          saw_non_digit_d = 1'b0;
        end
        CH_UP_R: begin
          has_result     = 1'b1;
          timer_colour_d = COL_RED;
          colour_d       = COL_RED;
        end
        CH_UP_Y: begin
          has_result     = 1'b1;
          timer_colour_d = COL_YELLOW;
          colour_d       = COL_YELLOW;
        end
        CH_UP_G: begin
          has_result     = 1'b1;
          timer_colour_d = COL_GREEN;
          colour_d       = COL_GREEN;
        end
        CH_UP_D: begin
          has_result   = 1'b1;
          debug_flag_d = !debug_flag_q;
          kind_d       = EV_DEBUG;
          dbg_d        = !debug_flag_q;
        end
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && (advance || !has_result);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire && has_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      entry_active_q  <= 1'b0;
      entry_count_q   <= '0;
      saw_non_digit_q <= 1'b0;
      timer_colour_q  <= COL_RED;
      debug_flag_q    <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        entry_active_q  <= entry_active_d;
        entry_count_q   <= entry_count_d;
        saw_non_digit_q <= saw_non_digit_d;
        timer_colour_q  <= timer_colour_d;
        debug_flag_q    <= debug_flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= rx_byte_i;
    end
    if (fire && store_we) begin
      digit_store_q[entry_count_q] <= cur_digit;
    end
    if (fire && has_result) begin
      kind_q   <= kind_d;
      colour_q <= colour_d;
      secs_q   <= secs_d;
      err_q    <= err_d;
      dbg_q    <= dbg_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign light_colour_o  = colour_q;
  assign delay_seconds_o = secs_q;
  assign error_code_o    = err_q;
  assign debug_enabled_o = dbg_q;

`ifndef ASSERT_OFF
  a_count_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_count_q != 3'd0) |-> entry_active_q)
    else $error("entry count nonzero outside time entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q < 3'(EntryLen))
    else $error("entry count past entry length");

  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == EV_TIMER) |-> (secs_q < SecsW'(86400)))
    else $error("timer delay out of range");

  a_secs_only_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != EV_TIMER) |-> (secs_q == '0))
    else $error("delay set on a non-timer event");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");
`endif

endmodule

### src/scp_time_check.sv
// Range check and seconds conversion of six HHMMSS digits.
// Depends on scp_pkg.
module scp_time_check (
  input  scp_pkg::digits_t  digits_i,
  output scp_pkg::time_res_t res_o
);
  import scp_pkg::*;

  logic [6:0] hours, mins, secs;

  assign hours = 7'(digits_i[0]) * 7'd10 + 7'(digits_i[1]);
  assign mins  = 7'(digits_i[2]) * 7'd10 + 7'(digits_i[3]);
  assign secs  = 7'(digits_i[4]) * 7'd10 + 7'(digits_i[5]);

  assign res_o.range_err = (hours > MAX_HOURS) || (mins > MAX_MINSEC) || (secs > MAX_MINSEC);
  assign res_o.secs      = SecsW'(hours) * SecsW'(3600) + SecsW'(mins) * SecsW'(60)
                         + SecsW'(secs);

endmodule
